// ===== src/salc_pkg.sv =====
// Shared widths and the command bundle of the set-associative LRU cache tag block.
`timescale 1ns / 1ps
package salc_pkg;
	localparam int TAG_W = 27;
	localparam int CFG_W = 3;
	localparam int WAY_W = 4;
	localparam int SET_W = 8;
	localparam int CNT_W = 32;
	localparam int ADDR_W = 32;
	localparam logic [CFG_W-1:0] WAYS_LOG2_RST = 3'd2;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;
endpackage

// ===== src/salc_ctrl.sv =====
// Controller state machine: accepts one item, then commits its lookup into the output register.
`timescale 1ns / 1ps
module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output salc_pkg::cmd_t    cmd
);
	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	// The result may only be loaded once the output register is free or being emptied.
	assign cmd.commit = (state_q == ST_CMP) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== src/salc_dp.sv =====
// Datapath: set/tag split, row memories, hit and victim selection, LRU rank update, counters.
`timescale 1ns / 1ps
module salc_dp #(
	parameter int TOTAL_LINES      = 512,
	parameter int LINE_OFFSET_BITS = 5,
	parameter int MAX_WAYS         = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [salc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [salc_pkg::ADDR_W-1:0]     address,
	input  salc_pkg::cmd_t                  cmd,
	output logic                            hit,
	output logic [salc_pkg::WAY_W-1:0]      way_used,
	output logic [salc_pkg::SET_W-1:0]      set_used,
	output logic [salc_pkg::CNT_W-1:0]      hit_total,
	output logic [salc_pkg::CNT_W-1:0]      access_total
);
	localparam int LOG_LINES = $clog2(TOTAL_LINES);
	localparam int IDX_W     = $clog2(MAX_WAYS);
	localparam int LIM       = (IDX_W < LOG_LINES) ? IDX_W : LOG_LINES;
	localparam int ROWS      = TOTAL_LINES / MAX_WAYS;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SH_W      = $clog2(LOG_LINES + LINE_OFFSET_BITS + 1);
	localparam int TAG_W     = salc_pkg::TAG_W;
	localparam int CFG_W     = salc_pkg::CFG_W;
	localparam int CNT_W     = salc_pkg::CNT_W;

	// One memory row holds MAX_WAYS consecutive lines; a set never straddles two rows.
	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [ROWS];
	logic [MAX_WAYS-1:0]            vld_mem [ROWS];
	logic [MAX_WAYS-1:0][IDX_W-1:0] rnk_mem [ROWS];
	logic [ROWS-1:0]                rowv_q;

	logic [CFG_W-1:0] wl_raw_q, wl_eff;
	logic [CNT_W-1:0] hit_cnt_q, acc_cnt_q;

	logic [LOG_LINES-1:0] line_bits, set_mask, set_d, line_d;
	logic [SH_W-1:0]      tag_sh;
	logic [salc_pkg::ADDR_W-1:0] tag_full;
	logic [ROW_W-1:0]     row_d;

	logic [TAG_W-1:0]     tag_s1;
	logic [LOG_LINES-1:0] set_s1;
	logic [IDX_W-1:0]     off_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [CFG_W-1:0]     wl_s1;
	logic                 rowv_s1;
	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_s1;
	logic [MAX_WAYS-1:0]            vld_rd_s1;
	logic [MAX_WAYS-1:0][IDX_W-1:0] rnk_rd_s1;

	logic [IDX_W-1:0]    maskw, sel, way_full;
	logic [IDX_W:0]      ways_n, old_rank;
	logic [MAX_WAYS-1:0] in_set, vv, hitv, inv, lru;
	logic                hit_any, have_inv;
	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_nx;
	logic [MAX_WAYS-1:0]            vld_nx;
	logic [MAX_WAYS-1:0][IDX_W-1:0] rnk_nx;

	logic                        hit_q;
	logic [salc_pkg::WAY_W-1:0]  way_q;
	logic [salc_pkg::SET_W-1:0]  set_q;

	function automatic logic [IDX_W-1:0] first_one(input logic [MAX_WAYS-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	// Clamp the ways register into the legal range.
	always_comb begin
		wl_eff = wl_raw_q;
		if (wl_eff > CFG_W'(LIM)) wl_eff = CFG_W'(LIM);
		if (wl_eff < CFG_W'(1)) wl_eff = CFG_W'(1);
	end

	always_comb begin
		line_bits = address[LINE_OFFSET_BITS +: LOG_LINES];
		set_mask  = {LOG_LINES{1'b1}} >> wl_eff;
		set_d     = line_bits & set_mask;
		line_d    = set_d << wl_eff;
		tag_sh    = SH_W'(LOG_LINES + LINE_OFFSET_BITS) - SH_W'(wl_eff);
		tag_full  = address >> tag_sh;
		row_d     = ROW_W'(line_d >> IDX_W);
	end

	// Lookup over the entries of the registered row; the set is an aligned block of it.
	always_comb begin
		maskw  = {IDX_W{1'b1}} >> (CFG_W'(IDX_W) - wl_s1);
		ways_n = (IDX_W + 1)'(1) << wl_s1;
		for (int e = 0; e < MAX_WAYS; e++) begin
			in_set[e] = ((IDX_W'(e) & ~maskw) == off_s1);
			vv[e]     = rowv_s1 && vld_rd_s1[e] && in_set[e];
			hitv[e]   = vv[e] && (tag_rd_s1[e] == tag_s1);
			inv[e]    = in_set[e] && !vv[e];
			lru[e]    = in_set[e] && (rnk_rd_s1[e] == maskw);
		end
		hit_any  = |hitv;
		have_inv = |inv;
		// With every way valid the ranks form a permutation, so the oldest way has the top rank.
		if (hit_any) begin
			sel      = first_one(hitv);
			old_rank = {1'b0, rnk_rd_s1[sel]};
		end else if (have_inv) begin
			sel      = first_one(inv);
			old_rank = ways_n;
		end else begin
			sel      = first_one(lru);
			old_rank = {1'b0, maskw};
		end
		way_full = sel & maskw;
		for (int e = 0; e < MAX_WAYS; e++) begin
			tag_nx[e] = tag_rd_s1[e];
			vld_nx[e] = rowv_s1 && vld_rd_s1[e];
			rnk_nx[e] = rnk_rd_s1[e];
			if (IDX_W'(e) == sel) begin
				tag_nx[e] = tag_s1;
				vld_nx[e] = 1'b1;
				rnk_nx[e] = '0;
			end else if (vv[e] && ({1'b0, rnk_rd_s1[e]} < old_rank)) begin
				rnk_nx[e] = rnk_rd_s1[e] + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_s1    <= tag_full[TAG_W-1:0];
			set_s1    <= set_d;
			off_s1    <= line_d[IDX_W-1:0];
			row_s1    <= row_d;
			wl_s1     <= wl_eff;
			tag_rd_s1 <= tag_mem[row_d];
			vld_rd_s1 <= vld_mem[row_d];
			rnk_rd_s1 <= rnk_mem[row_d];
		end
		if (cmd.commit) begin
			tag_mem[row_s1] <= tag_nx;
			vld_mem[row_s1] <= vld_nx;
			rnk_mem[row_s1] <= rnk_nx;
			hit_q           <= hit_any;
			way_q           <= salc_pkg::WAY_W'(32'(way_full));
			set_q           <= salc_pkg::SET_W'(32'(set_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_raw_q  <= salc_pkg::WAYS_LOG2_RST;
			rowv_q    <= '0;
			rowv_s1   <= 1'b0;
			hit_cnt_q <= '0;
			acc_cnt_q <= '0;
		end else begin
			if (cmd.load) rowv_s1 <= rowv_q[row_d];
			if (cfg_we) begin
				wl_raw_q <= cfg_wdata;
				rowv_q   <= '0;
			end else if (cmd.commit) begin
				rowv_q[row_s1] <= 1'b1;
			end
			if (cmd.commit) begin
				if (acc_cnt_q != '1) acc_cnt_q <= acc_cnt_q + CNT_W'(1);
				if (hit_any && hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end
		end
	end

	assign hit          = hit_q;
	assign way_used     = way_q;
	assign set_used     = set_q;
	assign hit_total    = hit_cnt_q;
	assign access_total = acc_cnt_q;
endmodule

// ===== src/set_assoc_lru_cache_tags_top.sv =====
// Top level of the set-associative cache tag and LRU block.
// An accepted item's row and fields are registered on accept; its result enters the output register on commit.
// A new item is accepted only after the previous one is committed, as the row is read on accept, written on commit.
// A full output register that is not taken holds the block in its compare cycle.
// Reset (asynchronous, active low) marks every row empty, zeroes counters, sets 4 ways.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags_top #(
	parameter int TOTAL_LINES      = 512,
	parameter int LINE_OFFSET_BITS = 5,
	parameter int MAX_WAYS         = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ways_log2_we,
	input  logic [salc_pkg::CFG_W-1:0]      ways_log2_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [salc_pkg::ADDR_W-1:0]     address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [salc_pkg::WAY_W-1:0]      way_used,
	output logic [salc_pkg::SET_W-1:0]      set_used,
	output logic [salc_pkg::CNT_W-1:0]      hit_total,
	output logic [salc_pkg::CNT_W-1:0]      access_total
);
	// The controller issues a load when an item is taken and a commit when the
	// looked-up row is written back and the result enters the output register.
	salc_pkg::cmd_t cmd;

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath reads the addressed memory row at the accept edge, so the
	// compare cycle works from registered row data and writes the row back once.
	salc_dp #(
		.TOTAL_LINES      (TOTAL_LINES),
		.LINE_OFFSET_BITS (LINE_OFFSET_BITS),
		.MAX_WAYS         (MAX_WAYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (ways_log2_we),
		.cfg_wdata    (ways_log2_wdata),
		.address      (address),
		.cmd          (cmd),
		.hit          (hit),
		.way_used     (way_used),
		.set_used     (set_used),
		.hit_total    (hit_total),
		.access_total (access_total)
	);

	// Only one item is in the datapath at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while a lookup is in progress");

	a_load_commit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.commit))
		else $error("load and commit in the same cycle");

	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_total <= access_total)
		else $error("hit count exceeds access count");

	a_commit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && access_total != '1 |=> access_total == $past(access_total) + 1)
		else $error("access count did not advance on commit");
endmodule
